### rtl/kmlc_pkg.sv
// ----------------------------------------------------------------------------
// kmlc_pkg
// Shared types and constants of the k-means clusterer.
// ----------------------------------------------------------------------------
package kmlc_pkg;

    localparam int MAX_POINTS   = 1024;
    localparam int MAX_DIMS     = 16;
    localparam int MAX_CLUSTERS = 16;
    localparam int COORD_BITS   = 16;

    localparam int PT_BITS   = $clog2(MAX_POINTS);
    localparam int DIM_BITS  = $clog2(MAX_DIMS);
    localparam int CL_BITS   = $clog2(MAX_CLUSTERS);
    localparam int CNT_BITS  = PT_BITS + 1;
    localparam int SUM_BITS  = COORD_BITS + PT_BITS;
    localparam int SQ_BITS   = 2 * (COORD_BITS + 1);
    localparam int DIST_BITS = SQ_BITS + DIM_BITS;

    localparam logic [2:0] OP_LOAD_POINT    = 3'd0;
    localparam logic [2:0] OP_LOAD_CENTROID = 3'd1;
    localparam logic [2:0] OP_RUN           = 3'd2;
    localparam logic [2:0] OP_READ_LABEL    = 3'd3;
    localparam logic [2:0] OP_READ_CENTROID = 3'd4;

    localparam logic [1:0] KIND_RUN_DONE  = 2'd0;
    localparam logic [1:0] KIND_LABEL     = 2'd1;
    localparam logic [1:0] KIND_CENTROID  = 2'd2;

    localparam logic [2:0] REG_NUM_POINTS   = 3'd0;
    localparam logic [2:0] REG_NUM_DIMS     = 3'd1;
    localparam logic [2:0] REG_NUM_CLUSTERS = 3'd2;
    localparam logic [2:0] REG_MAX_ITER     = 3'd3;
    localparam logic [2:0] REG_INIT_MODE    = 3'd4;

    typedef struct packed {
        logic                       start;
        logic signed [SUM_BITS-1:0] dividend;
        logic [CNT_BITS-1:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic                       done;
        logic signed [SUM_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

### rtl/kmlc_ram.sv
// ----------------------------------------------------------------------------
// kmlc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module kmlc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/kmlc_div.sv
// ----------------------------------------------------------------------------
// kmlc_div
// Radix-2 restoring divider: signed sum by unsigned count, truncated to zero.
// ----------------------------------------------------------------------------
module kmlc_div
    import kmlc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int STEP_BITS = $clog2(SUM_BITS + 1);

    logic [SUM_BITS-1:0]  q_reg, q_next;
    logic [CNT_BITS-1:0]  r_reg, r_next;
    logic [CNT_BITS-1:0]  d_reg, d_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 busy_reg, busy_next;
    logic                 neg_reg, neg_next;
    logic                 done_reg, done_next;
    logic [CNT_BITS:0]    shifted;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        shifted   = {r_reg, q_reg[SUM_BITS-1]};
        if (req.start) begin
            neg_next  = req.dividend[SUM_BITS-1];
            q_next    = req.dividend[SUM_BITS-1] ? SUM_BITS'(-req.dividend)
                                                 : SUM_BITS'(req.dividend);
            r_next    = '0;
            d_next    = req.divisor;
            step_next = STEP_BITS'(SUM_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // shift in one dividend bit, subtract when it fits
            if (shifted >= {1'b0, d_reg}) begin
                r_next = CNT_BITS'(shifted - {1'b0, d_reg});
                q_next = {q_reg[SUM_BITS-2:0], 1'b1};
            end else begin
                r_next = shifted[CNT_BITS-1:0];
                q_next = {q_reg[SUM_BITS-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        q_reg    <= q_next;
        r_reg    <= r_next;
        d_reg    <= d_next;
        step_reg <= step_next;
        neg_reg  <= neg_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule

### rtl/kmeans_lloyd_clusterer_unit.sv
// ----------------------------------------------------------------------------
// kmeans_lloyd_clusterer_unit
// Lloyd k-means over points, centroids and labels held in on-chip RAM.
// ----------------------------------------------------------------------------
// Load and read items each take one transfer on s_; loads finish in the
// accepting cycle and may follow back to back, a read's result passes the
// RAM read register, then the result register. A run item holds the input
// off until it ends: every iteration walks points x clusters x dims through
// the point and centroid RAMs (read, square, accumulate per coordinate; setup
// and label write per point), then rebuilds the centroids (fetch, label, next
// per point; read, add per coordinate of each labelled point; per cluster a
// count check and, if not empty, a bit-serial division per dim). The optional
// initial rebuild runs the same way. There is no clearing pass: the coordinate
// sum RAM is qualified by per-cluster counts.
module kmeans_lloyd_clusterer_unit
    import kmlc_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration writes
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [2:0]                   cfg_index,
    input  logic [10:0]                  cfg_data,
    // input items
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [2:0]                   s_op,
    input  logic [9:0]                   s_item_index,
    input  logic [3:0]                   s_dim_index,
    input  logic signed [15:0]           s_coord_value,
    input  logic [3:0]                   s_init_label,
    // result items
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_result_kind,
    output logic [3:0]                   m_label_out,
    output logic signed [15:0]           m_centroid_value,
    output logic [7:0]                   m_iterations_done,
    output logic                         m_converged
);

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_RD_LAB  = 5'd1;
    localparam logic [4:0] ST_RD_CEN  = 5'd2;
    localparam logic [4:0] ST_ITER    = 5'd3;
    localparam logic [4:0] ST_A_PT    = 5'd4;
    localparam logic [4:0] ST_A_RD    = 5'd5;
    localparam logic [4:0] ST_A_SQ    = 5'd6;
    localparam logic [4:0] ST_A_ACC   = 5'd7;
    localparam logic [4:0] ST_A_WR    = 5'd8;
    localparam logic [4:0] ST_R_CLR   = 5'd9;
    localparam logic [4:0] ST_R_PT    = 5'd10;
    localparam logic [4:0] ST_R_LAB   = 5'd11;
    localparam logic [4:0] ST_R_RD    = 5'd12;
    localparam logic [4:0] ST_R_ADD   = 5'd13;
    localparam logic [4:0] ST_R_NEXT  = 5'd14;
    localparam logic [4:0] ST_R_DC    = 5'd15;
    localparam logic [4:0] ST_R_DRD   = 5'd16;
    localparam logic [4:0] ST_R_DST   = 5'd17;
    localparam logic [4:0] ST_R_DW    = 5'd18;
    localparam logic [4:0] ST_R_END   = 5'd19;

    localparam int PADDR_BITS = PT_BITS + DIM_BITS;
    localparam int CADDR_BITS = CL_BITS + DIM_BITS;

    // configuration registers
    logic [10:0] num_points_reg;
    logic [4:0]  num_dims_reg;
    logic [4:0]  num_clusters_reg;
    logic [7:0]  max_iter_reg;
    logic        init_mode_reg;

    // sequencer
    logic [4:0]            state_reg, state_next;
    logic [PT_BITS-1:0]    i_reg, i_next;
    logic [DIM_BITS-1:0]   j_reg, j_next;
    logic [CL_BITS-1:0]    c_reg, c_next;
    logic [CL_BITS-1:0]    lab_reg, lab_next;
    logic [CL_BITS-1:0]    old_lab_reg, old_lab_next;
    logic [CL_BITS-1:0]    best_c_reg, best_c_next;
    logic [DIST_BITS-1:0]  best_d_reg, best_d_next;
    logic [DIST_BITS-1:0]  dist_reg, dist_next;
    logic [SQ_BITS-1:0]    sq_reg, sq_next;
    logic [7:0]            iter_reg, iter_next;
    logic                  moved_reg, moved_next;
    logic                  after_assign_reg, after_assign_next;
    logic                  oob_reg, oob_next;
    logic [PT_BITS-1:0]    n_m1_reg, n_m1_next;
    logic [DIM_BITS-1:0]   p_m1_reg, p_m1_next;
    logic [CL_BITS-1:0]    k_m1_reg, k_m1_next;
    logic [CNT_BITS-1:0]   count_reg [MAX_CLUSTERS];
    logic                  count_clr, count_inc;

    // result register
    logic                     m_valid_reg, m_valid_next;
    logic [1:0]               kind_reg, kind_next;
    logic [3:0]               label_reg, label_next;
    logic signed [15:0]       cval_reg, cval_next;
    logic [7:0]               iters_reg, iters_next;
    logic                     conv_reg, conv_next;

    // RAM ports
    logic                    pt_we, cen_we, lab_we, sum_we;
    logic [PADDR_BITS-1:0]   pt_waddr, pt_raddr;
    logic [CADDR_BITS-1:0]   cen_waddr, cen_raddr, sum_waddr, sum_raddr;
    logic [PT_BITS-1:0]      lab_waddr, lab_raddr;
    logic [COORD_BITS-1:0]   pt_wdata, pt_rdata, cen_wdata, cen_rdata;
    logic [CL_BITS-1:0]      lab_wdata, lab_rdata;
    logic [SUM_BITS-1:0]     sum_wdata, sum_rdata;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic                  s_xfer;
    logic signed [16:0]    diff;
    logic signed [33:0]    prod;
    logic [DIST_BITS-1:0]  acc;
    logic signed [SUM_BITS-1:0] sum_base;

    assign cfg_ready = 1'b1;
    // loads need no result slot; other ops wait for the slot to drain
    assign s_ready = (state_reg == ST_IDLE) &&
                     (!m_valid_reg || m_ready ||
                      s_op == OP_LOAD_POINT || s_op == OP_LOAD_CENTROID);
    assign s_xfer  = s_valid && s_ready;

    assign diff = $signed({pt_rdata[COORD_BITS-1], pt_rdata}) -
                  $signed({cen_rdata[COORD_BITS-1], cen_rdata});
    assign prod = diff * diff;
    assign acc  = dist_reg + {{(DIST_BITS-SQ_BITS){1'b0}}, sq_reg};
    // a cluster with no count yet holds a stale sum: read it as zero
    assign sum_base = (count_reg[lab_reg] == '0) ? '0 : $signed(sum_rdata);

    always_comb begin
        state_next        = state_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        c_next            = c_reg;
        lab_next          = lab_reg;
        old_lab_next      = old_lab_reg;
        best_c_next       = best_c_reg;
        best_d_next       = best_d_reg;
        dist_next         = dist_reg;
        sq_next           = sq_reg;
        iter_next         = iter_reg;
        moved_next        = moved_reg;
        after_assign_next = after_assign_reg;
        oob_next          = oob_reg;
        n_m1_next         = n_m1_reg;
        p_m1_next         = p_m1_reg;
        k_m1_next         = k_m1_reg;
        count_clr         = 1'b0;
        count_inc         = 1'b0;

        m_valid_next = m_valid_reg && !m_ready;
        kind_next    = kind_reg;
        label_next   = label_reg;
        cval_next    = cval_reg;
        iters_next   = iters_reg;
        conv_next    = conv_reg;

        pt_we     = 1'b0;
        pt_waddr  = {s_item_index, s_dim_index};
        pt_wdata  = s_coord_value;
        pt_raddr  = {i_reg, j_reg};
        cen_we    = 1'b0;
        cen_waddr = {s_item_index[CL_BITS-1:0], s_dim_index};
        cen_wdata = s_coord_value;
        cen_raddr = {c_reg, j_reg};
        lab_we    = 1'b0;
        lab_waddr = s_item_index;
        lab_wdata = s_init_label;
        lab_raddr = i_reg;
        sum_we    = 1'b0;
        sum_waddr = {lab_reg, j_reg};
        sum_wdata = SUM_BITS'(sum_base + SUM_BITS'($signed(pt_rdata)));
        sum_raddr = {lab_reg, j_reg};

        div_req.start    = 1'b0;
        div_req.dividend = $signed(sum_rdata);
        div_req.divisor  = count_reg[c_reg];

        unique case (state_reg)
            ST_IDLE: begin
                lab_raddr = s_item_index;
                cen_raddr = {s_item_index[CL_BITS-1:0], s_dim_index};
                if (s_xfer) begin
                    unique case (s_op)
                        OP_LOAD_POINT: begin
                            pt_we  = 1'b1;
                            lab_we = 1'b1;
                        end
                        OP_LOAD_CENTROID: begin
                            cen_we = (s_item_index[PT_BITS-1:CL_BITS] == '0);
                        end
                        OP_RUN: begin
                            // clamp the registers into their usable ranges
                            n_m1_next = (num_points_reg == '0) ? '0 :
                                        (num_points_reg > 11'(MAX_POINTS)) ?
                                        PT_BITS'(MAX_POINTS - 1) :
                                        PT_BITS'(num_points_reg - 1'b1);
                            p_m1_next = (num_dims_reg == '0) ? '0 :
                                        (num_dims_reg > 5'(MAX_DIMS)) ?
                                        DIM_BITS'(MAX_DIMS - 1) :
                                        DIM_BITS'(num_dims_reg - 1'b1);
                            k_m1_next = (num_clusters_reg == '0) ? '0 :
                                        (num_clusters_reg > 5'(MAX_CLUSTERS)) ?
                                        CL_BITS'(MAX_CLUSTERS - 1) :
                                        CL_BITS'(num_clusters_reg - 1'b1);
                            iter_next         = '0;
                            after_assign_next = 1'b0;
                            state_next = init_mode_reg ? ST_R_CLR : ST_ITER;
                        end
                        OP_READ_LABEL: begin
                            state_next = ST_RD_LAB;
                        end
                        OP_READ_CENTROID: begin
                            oob_next   = (s_item_index[PT_BITS-1:CL_BITS] != '0);
                            state_next = ST_RD_CEN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RD_LAB: begin
                m_valid_next = 1'b1;
                kind_next    = KIND_LABEL;
                label_next   = lab_rdata;
                cval_next    = '0;
                iters_next   = '0;
                conv_next    = 1'b0;
                state_next   = ST_IDLE;
            end
            ST_RD_CEN: begin
                m_valid_next = 1'b1;
                kind_next    = KIND_CENTROID;
                label_next   = '0;
                cval_next    = oob_reg ? '0 : $signed(cen_rdata);
                iters_next   = '0;
                conv_next    = 1'b0;
                state_next   = ST_IDLE;
            end
            ST_ITER: begin
                if (iter_reg == max_iter_reg) begin
                    m_valid_next = 1'b1;
                    kind_next    = KIND_RUN_DONE;
                    label_next   = '0;
                    cval_next    = '0;
                    iters_next   = iter_reg;
                    conv_next    = 1'b0;
                    state_next   = ST_IDLE;
                end else begin
                    i_next     = '0;
                    moved_next = 1'b0;
                    state_next = ST_A_PT;
                end
            end
            ST_A_PT: begin
                c_next     = '0;
                j_next     = '0;
                dist_next  = '0;
                state_next = ST_A_RD;
            end
            ST_A_RD: begin
                state_next = ST_A_SQ;
            end
            ST_A_SQ: begin
                old_lab_next = lab_rdata;
                sq_next      = SQ_BITS'(unsigned'(prod));
                state_next   = ST_A_ACC;
            end
            ST_A_ACC: begin
                if (j_reg == p_m1_reg) begin
                    // strict compare keeps ties on the lowest cluster
                    if (c_reg == '0 || acc < best_d_reg) begin
                        best_d_next = acc;
                        best_c_next = c_reg;
                    end
                    dist_next = '0;
                    j_next    = '0;
                    if (c_reg == k_m1_reg) begin
                        state_next = ST_A_WR;
                    end else begin
                        c_next     = c_reg + 1'b1;
                        state_next = ST_A_RD;
                    end
                end else begin
                    dist_next  = acc;
                    j_next     = j_reg + 1'b1;
                    state_next = ST_A_RD;
                end
            end
            ST_A_WR: begin
                lab_we     = 1'b1;
                lab_waddr  = i_reg;
                lab_wdata  = best_c_reg;
                moved_next = moved_reg || (best_c_reg != old_lab_reg);
                if (i_reg == n_m1_reg) begin
                    after_assign_next = 1'b1;
                    state_next        = ST_R_CLR;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_A_PT;
                end
            end
            ST_R_CLR: begin
                count_clr  = 1'b1;
                i_next     = '0;
                state_next = ST_R_PT;
            end
            ST_R_PT: begin
                state_next = ST_R_LAB;
            end
            ST_R_LAB: begin
                lab_next = lab_rdata;
                j_next   = '0;
                // drop points whose label lies beyond the clusters in use
                state_next = (lab_rdata > k_m1_reg) ? ST_R_NEXT : ST_R_RD;
            end
            ST_R_RD: begin
                state_next = ST_R_ADD;
            end
            ST_R_ADD: begin
                sum_we = 1'b1;
                if (j_reg == p_m1_reg) begin
                    count_inc  = 1'b1;
                    state_next = ST_R_NEXT;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_R_RD;
                end
            end
            ST_R_NEXT: begin
                if (i_reg == n_m1_reg) begin
                    c_next     = '0;
                    state_next = ST_R_DC;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_R_PT;
                end
            end
            ST_R_DC: begin
                j_next = '0;
                if (count_reg[c_reg] != '0) begin
                    state_next = ST_R_DRD;
                end else if (c_reg == k_m1_reg) begin
                    state_next = ST_R_END;
                end else begin
                    c_next = c_reg + 1'b1;
                end
            end
            ST_R_DRD: begin
                sum_raddr  = {c_reg, j_reg};
                state_next = ST_R_DST;
            end
            ST_R_DST: begin
                div_req.start = 1'b1;
                state_next    = ST_R_DW;
            end
            ST_R_DW: begin
                if (div_rsp.done) begin
                    cen_we    = 1'b1;
                    cen_waddr = {c_reg, j_reg};
                    cen_wdata = div_rsp.quotient[COORD_BITS-1:0];
                    if (j_reg != p_m1_reg) begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_R_DRD;
                    end else if (c_reg == k_m1_reg) begin
                        state_next = ST_R_END;
                    end else begin
                        c_next     = c_reg + 1'b1;
                        state_next = ST_R_DC;
                    end
                end
            end
            ST_R_END: begin
                if (after_assign_reg) begin
                    iter_next = iter_reg + 1'b1;
                    if (!moved_reg) begin
                        m_valid_next = 1'b1;
                        kind_next    = KIND_RUN_DONE;
                        label_next   = '0;
                        cval_next    = '0;
                        iters_next   = iter_reg + 1'b1;
                        conv_next    = 1'b1;
                        state_next   = ST_IDLE;
                    end else begin
                        state_next = ST_ITER;
                    end
                end else begin
                    state_next = ST_ITER;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            num_points_reg   <= 11'd1024;
            num_dims_reg     <= 5'd16;
            num_clusters_reg <= 5'd16;
            max_iter_reg     <= 8'd100;
            init_mode_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_NUM_POINTS:   num_points_reg   <= cfg_data;
                    REG_NUM_DIMS:     num_dims_reg     <= cfg_data[4:0];
                    REG_NUM_CLUSTERS: num_clusters_reg <= cfg_data[4:0];
                    REG_MAX_ITER:     max_iter_reg     <= cfg_data[7:0];
                    REG_INIT_MODE:    init_mode_reg    <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
        i_reg            <= i_next;
        j_reg            <= j_next;
        c_reg            <= c_next;
        lab_reg          <= lab_next;
        old_lab_reg      <= old_lab_next;
        best_c_reg       <= best_c_next;
        best_d_reg       <= best_d_next;
        dist_reg         <= dist_next;
        sq_reg           <= sq_next;
        iter_reg         <= iter_next;
        moved_reg        <= moved_next;
        after_assign_reg <= after_assign_next;
        oob_reg          <= oob_next;
        n_m1_reg         <= n_m1_next;
        p_m1_reg         <= p_m1_next;
        k_m1_reg         <= k_m1_next;
        kind_reg         <= kind_next;
        label_reg        <= label_next;
        cval_reg         <= cval_next;
        iters_reg        <= iters_next;
        conv_reg         <= conv_next;
    end

    // per-cluster point counts: cleared at once when a rebuild starts
    always_ff @(posedge aclk) begin
        for (int c = 0; c < MAX_CLUSTERS; c++) begin
            if (count_clr) begin
                count_reg[c] <= '0;
            end else if (count_inc && lab_reg == CL_BITS'(c)) begin
                count_reg[c] <= count_reg[c] + 1'b1;
            end
        end
    end

    kmlc_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS * MAX_DIMS)) u_point_ram (
        .aclk(aclk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
        .raddr(pt_raddr), .rdata(pt_rdata)
    );

    kmlc_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_CLUSTERS * MAX_DIMS)) u_centroid_ram (
        .aclk(aclk), .we(cen_we), .waddr(cen_waddr), .wdata(cen_wdata),
        .raddr(cen_raddr), .rdata(cen_rdata)
    );

    kmlc_ram #(.WIDTH(CL_BITS), .DEPTH(MAX_POINTS)) u_label_ram (
        .aclk(aclk), .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
        .raddr(lab_raddr), .rdata(lab_rdata)
    );

    kmlc_ram #(.WIDTH(SUM_BITS), .DEPTH(MAX_CLUSTERS * MAX_DIMS)) u_sum_ram (
        .aclk(aclk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
        .raddr(sum_raddr), .rdata(sum_rdata)
    );

    kmlc_div u_div (
        .aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp)
    );

    assign m_valid           = m_valid_reg;
    assign m_result_kind     = kind_reg;
    assign m_label_out       = label_reg;
    assign m_centroid_value  = cval_reg;
    assign m_iterations_done = iters_reg;
    assign m_converged       = conv_reg;

endmodule
